// ===== sv/ptc_pkg.sv =====
package ptc_pkg;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  localparam logic REG_PAGE_OFFSET_BITS = 1'b0;
  localparam logic REG_CAPACITY_IN_USE  = 1'b1;

  localparam logic [4:0] PAGE_OFFSET_BITS_RESET = 5'd12;
  localparam logic [4:0] CAPACITY_RESET         = 5'd16;

  typedef struct packed {
    logic        command;
    logic [31:0] virtual_address;
    logic [15:0] process_id;
    logic [31:0] machine_address;
  } req_item_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] translated_address;
  } rsp_item_t;

  typedef struct packed {
    logic [4:0] page_offset_bits;
    logic [4:0] capacity_in_use;
  } cfg_t;

  typedef struct packed {
    logic [31:0] vpage;
    logic [15:0] pid;
    logic [31:0] mpage;
    logic [31:0] stamp;
  } entry_data_t;

  typedef struct packed {
    logic insert;
    logic refresh;
    logic touch;
    logic evict;
  } cell_cmd_t;

  typedef struct packed {
    logic        valid;
    logic        hit;
    logic        page_match;
    logic [31:0] mpage;
  } cell_stat_t;

  typedef struct packed {
    logic        found;
    logic [31:0] stamp;
  } cand_t;

endpackage

// ===== sv/ptc_cfg.sv =====
module ptc_cfg import ptc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic write_en;

  assign pready   = 1'b1;
  assign write_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.page_offset_bits <= PAGE_OFFSET_BITS_RESET;
      cfg.capacity_in_use  <= CAPACITY_RESET;
    end else if (write_en) begin
      unique case (paddr[2])
        REG_PAGE_OFFSET_BITS: cfg.page_offset_bits <= pwdata[4:0];
        REG_CAPACITY_IN_USE:  cfg.capacity_in_use  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_PAGE_OFFSET_BITS: prdata = {27'd0, cfg.page_offset_bits};
      REG_CAPACITY_IN_USE:  prdata = {27'd0, cfg.capacity_in_use};
      default:              prdata = 32'd0;
    endcase
  end

endmodule

// ===== sv/ptc_cell.sv =====
module ptc_cell import ptc_pkg::*; #(
  parameter int IW    = 4,
  parameter int INDEX = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  cell_cmd_t     cmd,
  input  entry_data_t   bus,
  output cell_stat_t    stat,
  input  cand_t         cand_in,
  input  logic [IW-1:0] idx_in,
  output cand_t         cand_out,
  output logic [IW-1:0] idx_out
);

  logic        valid;
  logic [31:0] vpage;
  logic [15:0] pid;
  logic [31:0] mpage;
  logic [31:0] stamp;
  logic        take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.insert) begin
      valid <= 1'b1;
    end else if (cmd.evict) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      vpage <= bus.vpage;
    end
    if (cmd.insert || cmd.refresh) begin
      pid   <= bus.pid;
      mpage <= bus.mpage;
    end
    if (cmd.insert || cmd.refresh || cmd.touch) begin
      stamp <= bus.stamp;
    end
  end

  assign stat.valid      = valid;
  assign stat.page_match = valid && (vpage == bus.vpage);
  assign stat.hit        = valid && (vpage != 32'd0) && (vpage == bus.vpage) &&
                           (pid == bus.pid) && (mpage != 32'd0);
  assign stat.mpage      = mpage;

  // The oldest entry so far travels one cell to the right each cycle.
  assign take = valid && (!cand_in.found || (stamp < cand_in.stamp));

  always_ff @(posedge clk) begin
    if (take) begin
      cand_out.found <= 1'b1;
      cand_out.stamp <= stamp;
      idx_out        <= IW'(INDEX);
    end else begin
      cand_out <= cand_in;
      idx_out  <= idx_in;
    end
  end

endmodule

// ===== sv/page_translation_cache_lru_unit.sv =====
// Fully associative page translation cache with least recently used
// replacement, tagged by process id.
// Items enter on the req channel (valid/ready) and each gives exactly one
// item on the rsp channel (valid/ready). A lookup answers the machine page
// ORed with the page offset on a hit; an update answers a miss with zero.
// Registers page_offset_bits and capacity_in_use sit on the APB port at
// byte addresses 0 and 4; they must be written by the user only while
// the block is idle, as the block itself does not enforce it. The block
// works on one item at a time. A lookup or an update that needs no
// eviction passes from the EXEC state to the RESP state, where its result
// is loaded into the output register. An update that must evict first
// waits in the SCAN state for the oldest-entry search to ripple along
// the row of cells, one cell per cycle, before it moves to RESP.
// A new item is accepted while the previous result still waits in the
// output register; if the receiver stalls, the next result waits in the
// block until the output register is free, and no further item is taken.
// A synchronous reset empties the table, clears the stamp counter and
// restores page_offset_bits to 12 and capacity_in_use to 16.
module page_translation_cache_lru_unit import ptc_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_item_t   req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_item_t   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FW   = $clog2(ENTRIES + 1);
  localparam int CMPW = (FW > 5) ? FW : 5;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXEC   = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_RESP   = 2'd3;

  cfg_t        cfg;
  logic [1:0]  state;
  logic [1:0]  state_next;
  req_item_t   item;
  logic [31:0] item_stamp;
  logic [31:0] stamp_counter;
  logic [FW-1:0] fill_count;
  logic [FW-1:0] scan_count;
  logic        res_hit;
  logic [31:0] res_addr;

  logic [31:0] offset_mask;
  entry_data_t bus;
  cell_cmd_t   cmds  [ENTRIES];
  cell_stat_t  stats [ENTRIES];
  cand_t       cand  [ENTRIES+1];
  logic [IW-1:0] idx [ENTRIES+1];

  logic          any_hit;
  logic [IW-1:0] hit_idx;
  logic          any_match;
  logic [IW-1:0] match_idx;
  logic          slot_ok;
  logic [IW-1:0] slot_idx;
  logic [CMPW-1:0] cap_eff;
  logic          full;
  logic          upd_live;
  logic          do_insert;
  logic          do_evict;
  logic          accept;
  logic          rsp_load;

  ptc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign offset_mask = ~(32'hFFFF_FFFF << cfg.page_offset_bits);
  assign bus.vpage   = item.virtual_address & ~offset_mask;
  assign bus.pid     = item.process_id;
  assign bus.mpage   = item.machine_address & ~offset_mask;
  assign bus.stamp   = item_stamp;

  assign cand[0] = '0;
  assign idx[0]  = '0;

  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    ptc_cell #(
      .IW    (IW),
      .INDEX (k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmds[k]),
      .bus      (bus),
      .stat     (stats[k]),
      .cand_in  (cand[k]),
      .idx_in   (idx[k]),
      .cand_out (cand[k+1]),
      .idx_out  (idx[k+1])
    );
  end

  always_comb begin
    any_hit   = 1'b0;
    hit_idx   = '0;
    any_match = 1'b0;
    match_idx = '0;
    slot_ok   = 1'b0;
    slot_idx  = '0;
    for (int k = ENTRIES - 1; k >= 0; k--) begin
      if (stats[k].hit) begin
        any_hit = 1'b1;
        hit_idx = IW'(k);
      end
      if (stats[k].page_match) begin
        any_match = 1'b1;
        match_idx = IW'(k);
      end
      if (!stats[k].valid ||
          (do_evict && (idx[ENTRIES] == IW'(k)))) begin
        slot_ok  = 1'b1;
        slot_idx = IW'(k);
      end
    end
  end

  assign cap_eff  = (CMPW'(cfg.capacity_in_use) > CMPW'(ENTRIES)) ?
                    CMPW'(ENTRIES) : CMPW'(cfg.capacity_in_use);
  assign full     = CMPW'(fill_count) >= cap_eff;
  assign upd_live = (item.command == CMD_UPDATE) && (cap_eff != '0) &&
                    (item.virtual_address != 32'd0);
  assign do_evict = (state == ST_SCAN) && (scan_count == FW'(ENTRIES - 1)) &&
                    cand[ENTRIES].found;
  assign do_insert = slot_ok &&
                     (((state == ST_EXEC) && upd_live && !any_match && !full) ||
                      ((state == ST_SCAN) && (scan_count == FW'(ENTRIES - 1))));

  always_comb begin
    for (int k = 0; k < ENTRIES; k++) begin
      cmds[k].insert  = do_insert && (slot_idx == IW'(k));
      cmds[k].evict   = do_evict && (idx[ENTRIES] == IW'(k));
      cmds[k].refresh = (state == ST_EXEC) && upd_live && any_match &&
                        (match_idx == IW'(k));
      cmds[k].touch   = (state == ST_EXEC) && (item.command == CMD_LOOKUP) &&
                        any_hit && (hit_idx == IW'(k));
    end
  end

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign rsp_load  = (state == ST_RESP) && (!rsp_valid || rsp_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (upd_live && !any_match && full) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_RESP;
        end
      end
      ST_SCAN: begin
        if (scan_count == FW'(ENTRIES - 1)) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (rsp_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      stamp_counter <= 32'd0;
      fill_count    <= '0;
      scan_count    <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        stamp_counter <= stamp_counter + 32'd1;
      end
      if (do_insert && !do_evict) begin
        fill_count <= fill_count + FW'(1);
      end else if (do_evict && !do_insert) begin
        fill_count <= fill_count - FW'(1);
      end
      if (state == ST_SCAN) begin
        scan_count <= scan_count + FW'(1);
      end else begin
        scan_count <= '0;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item       <= req;
      item_stamp <= stamp_counter;
    end
    if (state == ST_EXEC) begin
      res_hit  <= (item.command == CMD_LOOKUP) && any_hit;
      res_addr <= ((item.command == CMD_LOOKUP) && any_hit) ?
                  (stats[hit_idx].mpage | (item.virtual_address & offset_mask)) :
                  32'd0;
    end
    if (rsp_load) begin
      rsp.hit                <= res_hit;
      rsp.translated_address <= res_addr;
    end
  end

endmodule
